// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/core/pbic_pkg.sv -----
// ----------------------------------------------------------------------------
// pbic_pkg
// Types and constants shared by the power button and idle controller.
// ----------------------------------------------------------------------------
package pbic_pkg;

   localparam int unsigned TIME_W      = 32;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 20;

   // Standby causes as seen on the result channel
   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_BATTERY = 2'd1,
      CAUSE_LONG    = 2'd2,
      CAUSE_IDLE    = 2'd3
   } cause_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STANDBY_MINUTES    = 3'd0,
      CSR_LONG_PRESS_MS      = 3'd1,
      CSR_SHORT_PRESS_MIN_MS = 3'd2,
      CSR_CRITICAL_PERCENT   = 3'd3,
      CSR_CHECK_PERIOD_MS    = 3'd4,
      CSR_HITS_NEEDED        = 3'd5,
      CSR_MIN_VALID_MV       = 3'd6
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [7:0]  STANDBY_MINUTES_RST    = 8'd5;
   localparam logic [15:0] LONG_PRESS_MS_RST      = 16'd2000;
   localparam logic [15:0] SHORT_PRESS_MIN_MS_RST = 16'd40;
   localparam logic [6:0]  CRITICAL_PERCENT_RST   = 7'd5;
   localparam logic [19:0] CHECK_PERIOD_MS_RST    = 20'd30000;
   localparam logic [1:0]  HITS_NEEDED_RST        = 2'd2;
   localparam logic [15:0] MIN_VALID_MV_RST       = 16'd100;

   localparam logic [TIME_W-1:0] MS_PER_MINUTE     = 32'd60000;
   localparam logic [TIME_W-1:0] IDLE_LIMIT_MS_RST = 32'd300000;
   localparam logic [1:0]        HITS_MAX          = 2'd3;

   // Configuration as seen by the tick logic
   typedef struct packed {
      logic [7:0]        standby_minutes;
      logic [15:0]       long_press_ms;
      logic [15:0]       short_press_min_ms;
      logic [6:0]        critical_percent;
      logic [19:0]       check_period_ms;
      logic [1:0]        hits_needed;
      logic [15:0]       min_valid_mv;
      logic [TIME_W-1:0] idle_limit_ms;
   } cfg_type;

   // One poll tick
   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              button_down;
      logic              external_power;
      logic [15:0]       battery_mv;
      logic [6:0]        battery_pct;
      logic              playback_active;
      logic              file_server_active;
      logic              user_activity;
   } tick_type;

   // One result
   typedef struct packed {
      logic              keys_locked;
      logic              standby_request;
      cause_type         standby_cause;
      logic [TIME_W-1:0] idle_ms;
   } result_type;

endpackage

// ----- rtl/core/pbic_req_if.sv -----
// ----------------------------------------------------------------------------
// pbic_req_if
// Poll tick channel: valid/ready handshake with the tick fields.
// ----------------------------------------------------------------------------
interface pbic_req_if;
   import pbic_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_ms;
   logic              button_down;
   logic              external_power;
   logic [15:0]       battery_mv;
   logic [6:0]        battery_pct;
   logic              playback_active;
   logic              file_server_active;
   logic              user_activity;

   modport source (
      output valid, now_ms, button_down, external_power, battery_mv, battery_pct,
             playback_active, file_server_active, user_activity,
      input  ready
   );

   modport sink (
      input  valid, now_ms, button_down, external_power, battery_mv, battery_pct,
             playback_active, file_server_active, user_activity,
      output ready
   );
endinterface

// ----- rtl/core/pbic_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pbic_rsp_if
// Result channel: valid/ready handshake with lock state and standby request.
// ----------------------------------------------------------------------------
interface pbic_rsp_if;
   import pbic_pkg::*;

   logic              valid;
   logic              ready;
   logic              keys_locked;
   logic              standby_request;
   logic [1:0]        standby_cause;
   logic [TIME_W-1:0] idle_ms;

   modport source (
      output valid, keys_locked, standby_request, standby_cause, idle_ms,
      input  ready
   );

   modport sink (
      input  valid, keys_locked, standby_request, standby_cause, idle_ms,
      output ready
   );
endinterface

// ----- rtl/core/pbic_csr.sv -----
// ----------------------------------------------------------------------------
// pbic_csr
// Configuration registers; also keeps the idle limit in milliseconds so the
// tick logic compares against a ready value.
// ----------------------------------------------------------------------------
module pbic_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pbic_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pbic_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output pbic_pkg::cfg_type                  cfg
);
   import pbic_pkg::*;

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic [TIME_W-1:0] idle_limit_in;

   // Scale minutes to milliseconds from the minutes register; the product is registered in the cycle after it
   assign idle_limit_in = TIME_W'({24'd0, cfg_ff.standby_minutes} * MS_PER_MINUTE);

   // Decode a register write
   always_comb begin
      cfg_in               = cfg_ff;
      cfg_in.idle_limit_ms = idle_limit_in;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_STANDBY_MINUTES:    cfg_in.standby_minutes    = csr_wdata[7:0];
            CSR_LONG_PRESS_MS:      cfg_in.long_press_ms      = csr_wdata[15:0];
            CSR_SHORT_PRESS_MIN_MS: cfg_in.short_press_min_ms = csr_wdata[15:0];
            CSR_CRITICAL_PERCENT:   cfg_in.critical_percent   = csr_wdata[6:0];
            CSR_CHECK_PERIOD_MS:    cfg_in.check_period_ms    = csr_wdata;
            CSR_HITS_NEEDED:        cfg_in.hits_needed        = csr_wdata[1:0];
            CSR_MIN_VALID_MV:       cfg_in.min_valid_mv       = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.standby_minutes    <= STANDBY_MINUTES_RST;
         cfg_ff.long_press_ms      <= LONG_PRESS_MS_RST;
         cfg_ff.short_press_min_ms <= SHORT_PRESS_MIN_MS_RST;
         cfg_ff.critical_percent   <= CRITICAL_PERCENT_RST;
         cfg_ff.check_period_ms    <= CHECK_PERIOD_MS_RST;
         cfg_ff.hits_needed        <= HITS_NEEDED_RST;
         cfg_ff.min_valid_mv       <= MIN_VALID_MV_RST;
         cfg_ff.idle_limit_ms      <= IDLE_LIMIT_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/power_button_idle_controller_core.sv -----
// ----------------------------------------------------------------------------
// power_button_idle_controller_core
// Poll-tick controller for key lock, long-press standby, critical battery
// standby and idle timeout.
// ----------------------------------------------------------------------------
// Each accepted poll tick yields exactly one result. A tick is held in an
// input register while it is evaluated against the controller state, and its
// result is loaded into an output register once that register is empty or
// being taken, and is offered on the result channel from there. A new tick is
// taken every cycle as long as the result side keeps draining. The state
// update (press tracking, battery hit counter, activity time) is written as
// each result is loaded, which sets that one-tick-per-cycle rate. The idle
// limit in milliseconds follows the minutes register in the cycle after it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module power_button_idle_controller_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pbic_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pbic_pkg::CSR_DATA_W-1:0]  csr_wdata,
   pbic_req_if.sink                         req_chan,
   pbic_rsp_if.source                       rsp_chan
);
   import pbic_pkg::*;

   cfg_type           cfg;

   // Pipeline control and data
   logic              s1_valid_ff;
   logic              s1_valid_in;
   tick_type          s1_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   result_type        rsp_ff;
   result_type        rsp_in;
   logic              out_load;
   logic              req_take;

   // Controller state
   logic [TIME_W-1:0] last_act_ff, last_act_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic [TIME_W-1:0] last_check_ff, last_check_in;
   logic              press_valid_ff, press_valid_in;
   logic              long_fired_ff, long_fired_in;
   logic              lock_ff, lock_in;
   logic [1:0]        hits_ff, hits_in;

   // Tick evaluation
   cause_type         cause;
   logic              act_now;
   logic              check_due;
   logic              battery_low;
   logic [1:0]        hits_inc;
   logic [TIME_W-1:0] press_ms;
   logic [TIME_W-1:0] since_act;
   logic [TIME_W-1:0] now;

   pbic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: the output register frees when empty or being taken
   assign out_load       = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || out_load;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_take || (s1_valid_ff && !out_load);
   assign rsp_valid_in   = out_load || (rsp_valid_ff && !rsp_chan.ready);

   // Evaluate one tick against the state
   always_comb begin
      now            = s1_ff.now_ms;
      cause          = CAUSE_NONE;
      act_now        = s1_ff.user_activity;
      last_check_in  = last_check_ff;
      hits_in        = hits_ff;
      press_valid_in = press_valid_ff;
      press_start_in = press_start_ff;
      long_fired_in  = long_fired_ff;
      lock_in        = lock_ff;
      check_due      = (now - last_check_ff) >= {12'd0, cfg.check_period_ms};
      battery_low    = !s1_ff.external_power && (s1_ff.battery_mv > cfg.min_valid_mv) &&
                       (s1_ff.battery_pct <= cfg.critical_percent);
      hits_inc       = (hits_ff == HITS_MAX) ? HITS_MAX : hits_ff + 2'd1;
      press_ms       = now - press_start_ff;
      since_act      = now - last_act_ff;

      // Critical battery check once per period
      if (check_due) begin
         last_check_in = now;
         if (battery_low) begin
            hits_in = hits_inc;
            if (hits_inc >= cfg.hits_needed) begin
               cause = CAUSE_BATTERY;
            end
         end else begin
            hits_in = '0;
         end
      end

      // Button: track press, fire long press, toggle lock on a short release
      if (cause == CAUSE_NONE) begin
         if (s1_ff.button_down) begin
            if (!press_valid_ff) begin
               press_valid_in = 1'b1;
               press_start_in = now;
               long_fired_in  = 1'b0;
               act_now        = 1'b1;
            end else if (!long_fired_ff && (press_ms >= {16'd0, cfg.long_press_ms})) begin
               long_fired_in = 1'b1;
               cause         = CAUSE_LONG;
            end
         end else if (press_valid_ff) begin
            press_valid_in = 1'b0;
            press_start_in = '0;
            if (!long_fired_ff && (press_ms >= {16'd0, cfg.short_press_min_ms}) &&
                (press_ms < {16'd0, cfg.long_press_ms})) begin
               lock_in = !lock_ff;
               act_now = 1'b1;
            end
            long_fired_in = 1'b0;
         end
      end

      // Idle timeout; fresh activity this tick means zero idle time
      if ((cause == CAUSE_NONE) && (cfg.standby_minutes != 8'd0)) begin
         if (s1_ff.playback_active || (s1_ff.file_server_active && s1_ff.external_power)) begin
            act_now = 1'b1;
         end else if (!act_now && (since_act >= cfg.idle_limit_ms)) begin
            cause = CAUSE_IDLE;
         end
      end

      last_act_in            = act_now ? now : last_act_ff;
      rsp_in.keys_locked     = lock_in;
      rsp_in.standby_request = (cause != CAUSE_NONE);
      rsp_in.standby_cause   = cause;
      rsp_in.idle_ms         = act_now ? '0 : since_act;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_act_ff    <= '0;
         press_start_ff <= '0;
         last_check_ff  <= '0;
         press_valid_ff <= 1'b0;
         long_fired_ff  <= 1'b0;
         lock_ff        <= 1'b0;
         hits_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (out_load) begin
            last_act_ff    <= last_act_in;
            press_start_ff <= press_start_in;
            last_check_ff  <= last_check_in;
            press_valid_ff <= press_valid_in;
            long_fired_ff  <= long_fired_in;
            lock_ff        <= lock_in;
            hits_ff        <= hits_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff.now_ms             <= req_chan.now_ms;
         s1_ff.button_down        <= req_chan.button_down;
         s1_ff.external_power     <= req_chan.external_power;
         s1_ff.battery_mv         <= req_chan.battery_mv;
         s1_ff.battery_pct        <= req_chan.battery_pct;
         s1_ff.playback_active    <= req_chan.playback_active;
         s1_ff.file_server_active <= req_chan.file_server_active;
         s1_ff.user_activity      <= req_chan.user_activity;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.keys_locked     = rsp_ff.keys_locked;
   assign rsp_chan.standby_request = rsp_ff.standby_request;
   assign rsp_chan.standby_cause   = rsp_ff.standby_cause;
   assign rsp_chan.idle_ms         = rsp_ff.idle_ms;

   // Checks
   `ASSERT_PROP(a_long_sets_fired, clock, reset,
      out_load && (cause == CAUSE_LONG) |=> long_fired_ff, "long press did not latch fired")
   `ASSERT_PROP(a_lock_only_on_tick, clock, reset,
      !out_load |=> $stable(lock_ff), "key lock changed without a tick")
   `ASSERT_PROP(a_press_start_on_button, clock, reset,
      $rose(press_valid_ff) |-> $past(out_load && s1_ff.button_down),
      "press tracking started without a pressed tick")
   `ASSERT_PROP(a_stage_holds_on_stall, clock, reset,
      s1_valid_ff && !out_load |=> s1_valid_ff, "pending tick dropped during stall")

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for power_button_idle_controller_core.
// A directed table walks presses, battery checks, idle timeouts and time wrap
// at the reset settings. Random poll-tick sequences then run under several
// register settings, extremes included. Each result is compared in order against
// the table's value for typed rows and a bench prediction otherwise.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pbic_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;

   // One line of the directed table
   typedef struct {
      tick_type   tick;
      bit         typed;
      result_type outcome;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pbic_req_if req_chan ();
   pbic_rsp_if rsp_chan ();

   power_button_idle_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // Settings as the controller should see them
   logic [7:0]  cfg_minutes  = STANDBY_MINUTES_RST;
   logic [15:0] cfg_long     = LONG_PRESS_MS_RST;
   logic [15:0] cfg_short    = SHORT_PRESS_MIN_MS_RST;
   logic [6:0]  cfg_crit     = CRITICAL_PERCENT_RST;
   logic [19:0] cfg_period   = CHECK_PERIOD_MS_RST;
   logic [1:0]  cfg_hits     = HITS_NEEDED_RST;
   logic [15:0] cfg_min_mv   = MIN_VALID_MV_RST;

   // Controller state as predicted
   logic [31:0] act_ms       = '0;
   logic [31:0] press_ms     = '0;
   logic [31:0] check_ms     = '0;
   bit          pressing     = 1'b0;
   bit          long_fired   = 1'b0;
   bit          locked       = 1'b0;
   int          hits         = 0;

   result_type  pending_results[$];
   dir_row_type dir_rows[$];
   logic [31:0] sim_now      = '0;
   bit          send_calm    = 1'b0;
   bit          recv_calm    = 1'b0;
   int          ticks_sent   = 0;
   int          results_checked = 0;
   int          error_count  = 0;
   int          lock_toggles = 0;
   int          settings_loaded = 1;
   int          standby_by_cause[4] = '{0, 0, 0, 0};
   int          stall_cycles = 0;

   // Free-running clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Work out the result of one poll tick and advance the predicted state
   function automatic result_type poll_outcome(input tick_type t);
      result_type  r;
      cause_type   cause;
      logic [31:0] span;
      logic [31:0] idle_limit;
      cause = CAUSE_NONE;
      if (t.user_activity) act_ms = t.now_ms;

      // battery check once per period
      span = t.now_ms - check_ms;
      if (span >= {12'd0, cfg_period}) begin
         check_ms = t.now_ms;
         if (!t.external_power && t.battery_mv > cfg_min_mv &&
             t.battery_pct <= cfg_crit) begin
            if (hits < 3) hits++;
            if (hits >= cfg_hits) cause = CAUSE_BATTERY;
         end else begin
            hits = 0;
         end
      end

      // button press tracking
      if (cause == CAUSE_NONE) begin
         if (t.button_down) begin
            if (!pressing) begin
               pressing   = 1'b1;
               press_ms   = t.now_ms;
               long_fired = 1'b0;
               act_ms     = t.now_ms;
            end else if (!long_fired && (t.now_ms - press_ms) >= {16'd0, cfg_long}) begin
               long_fired = 1'b1;
               cause      = CAUSE_LONG;
            end
         end else if (pressing) begin
            span     = t.now_ms - press_ms;
            pressing = 1'b0;
            press_ms = '0;
            if (!long_fired && span >= {16'd0, cfg_short} && span < {16'd0, cfg_long}) begin
               locked = !locked;
               act_ms = t.now_ms;
               lock_toggles++;
            end
            long_fired = 1'b0;
         end
      end

      // idle timeout, held off by playback or served files on mains
      if (cause == CAUSE_NONE && cfg_minutes != 8'd0) begin
         idle_limit = {24'd0, cfg_minutes} * MS_PER_MINUTE;
         if (t.playback_active || (t.file_server_active && t.external_power)) begin
            act_ms = t.now_ms;
         end else if ((t.now_ms - act_ms) >= idle_limit) begin
            cause = CAUSE_IDLE;
         end
      end

      r.keys_locked     = locked;
      r.standby_request = (cause != CAUSE_NONE);
      r.standby_cause   = cause;
      r.idle_ms         = t.now_ms - act_ms;
      return r;
   endfunction

   function automatic tick_type make_tick(input logic [31:0] now, input bit btn, input bit ext,
                                          input logic [15:0] mv, input logic [6:0] pct,
                                          input bit play, input bit fsrv, input bit act);
      tick_type t;
      t.now_ms             = now;
      t.button_down        = btn;
      t.external_power     = ext;
      t.battery_mv         = mv;
      t.battery_pct        = pct;
      t.playback_active    = play;
      t.file_server_active = fsrv;
      t.user_activity      = act;
      return t;
   endfunction

   function automatic dir_row_type row(input tick_type t, input bit typed, input bit lock,
                                       input bit req, input cause_type cause,
                                       input logic [31:0] idle);
      dir_row_type d;
      d.tick                    = t;
      d.typed                   = typed;
      d.outcome.keys_locked     = lock;
      d.outcome.standby_request = req;
      d.outcome.standby_cause   = cause;
      d.outcome.idle_ms         = idle;
      return d;
   endfunction

   // Offer one tick, hold it until taken, then queue its expected result
   task automatic send_tick(input tick_type t, input bit typed, input result_type typed_res);
      int         gap;
      result_type predicted;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
      end
      @(negedge clock);
      req_chan.now_ms             = t.now_ms;
      req_chan.button_down        = t.button_down;
      req_chan.external_power     = t.external_power;
      req_chan.battery_mv         = t.battery_mv;
      req_chan.battery_pct        = t.battery_pct;
      req_chan.playback_active    = t.playback_active;
      req_chan.file_server_active = t.file_server_active;
      req_chan.user_activity      = t.user_activity;
      req_chan.valid              = 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = poll_outcome(t);
      pending_results.push_back(typed ? typed_res : predicted);
      ticks_sent++;
   endtask

   // Drop valid and hold off until every expected result has come back
   task automatic await_quiet();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [19:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_STANDBY_MINUTES:    cfg_minutes = value[7:0];
         CSR_LONG_PRESS_MS:      cfg_long    = value[15:0];
         CSR_SHORT_PRESS_MIN_MS: cfg_short   = value[15:0];
         CSR_CRITICAL_PERCENT:   cfg_crit    = value[6:0];
         CSR_CHECK_PERIOD_MS:    cfg_period  = value;
         CSR_HITS_NEEDED:        cfg_hits    = value[1:0];
         CSR_MIN_VALID_MV:       cfg_min_mv  = value[15:0];
         default: ;
      endcase
   endtask

   // Reprogram every register while the controller is idle
   task automatic load_settings(input logic [19:0] minutes, input logic [19:0] long_ms,
                                input logic [19:0] short_ms, input logic [19:0] crit,
                                input logic [19:0] period, input logic [19:0] hits_req,
                                input logic [19:0] min_mv);
      await_quiet();
      write_register(CSR_STANDBY_MINUTES, minutes);
      write_register(CSR_LONG_PRESS_MS, long_ms);
      write_register(CSR_SHORT_PRESS_MIN_MS, short_ms);
      write_register(CSR_CRITICAL_PERCENT, crit);
      write_register(CSR_CHECK_PERIOD_MS, period);
      write_register(CSR_HITS_NEEDED, hits_req);
      write_register(CSR_MIN_VALID_MV, min_mv);
      @(negedge clock);
      csr_we = 1'b0;
      settings_loaded++;
   endtask

   // Plausible tick sequences: time steps scaled to the settings, press and
   // low-battery episodes, supply changes, with a little raw noise
   task automatic random_phase(input int count);
      tick_type    t;
      int          press_left;
      int          low_left;
      int          pick;
      int          span;
      int          crit_top;
      int          err_top;
      bit          ext_level;
      logic [63:0] noise;
      press_left = 0;
      low_left   = 0;
      ext_level  = 1'b0;
      if ($urandom_range(0, 3) == 0) sim_now = $urandom;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) span = cfg_short + 8;
         else if (pick < 70) span = cfg_long / 2 + 8;
         else if (pick < 85) span = cfg_period + 8;
         else if (pick < 96) span = (cfg_minutes == 0) ? 100000 : cfg_minutes * 30000 + 8;
         else span = 2000000;
         sim_now = sim_now + $urandom_range(0, span);
         t.now_ms = sim_now;

         if (press_left == 0 && $urandom_range(0, 5) == 0) press_left = $urandom_range(1, 8);
         t.button_down = (press_left > 0);
         if (press_left > 0) press_left--;

         if ($urandom_range(0, ext_level ? 9 : 39) == 0) ext_level = !ext_level;
         t.external_power = ext_level;

         if (low_left == 0 && $urandom_range(0, 29) == 0) low_left = $urandom_range(5, 40);
         crit_top = (cfg_crit > 100) ? 100 : cfg_crit;
         t.battery_pct = (low_left > 0) ? 7'($urandom_range(0, crit_top)) :
                                          7'($urandom_range(0, 100));
         if (low_left > 0) low_left--;

         err_top = (cfg_min_mv == 16'hFFFF) ? 65535 : cfg_min_mv + 1;
         pick = $urandom_range(0, 9);
         if (pick < 8) t.battery_mv = 16'($urandom_range(3000, 4200));
         else if (pick == 8) t.battery_mv = 16'($urandom_range(0, err_top));
         else t.battery_mv = 16'($urandom_range(0, 65535));

         t.playback_active    = ($urandom_range(0, 14) == 0);
         t.file_server_active = ($urandom_range(0, 5) == 0);
         t.user_activity      = ($urandom_range(0, 11) == 0);

         // raw noise, time may jump anywhere
         if ($urandom_range(0, 99) == 0) begin
            noise = {$urandom, $urandom};
            t = tick_type'(noise[$bits(tick_type)-1:0]);
            t.battery_pct = 7'($urandom_range(0, 100));
         end

         if ($urandom_range(0, 199) == 0) await_quiet();
         send_tick(t, 1'b0, '0);
      end
   endtask

   // Compare one result transaction with the oldest expectation
   task automatic check_result();
      result_type got;
      result_type want;
      got.keys_locked     = rsp_chan.keys_locked;
      got.standby_request = rsp_chan.standby_request;
      got.standby_cause   = cause_type'(rsp_chan.standby_cause);
      got.idle_ms         = rsp_chan.idle_ms;
      if (pending_results.size() == 0) begin
         if (error_count < 10)
            $display("%0t: result with nothing expected: lock=%0b req=%0b cause=%0d idle=%0d",
                     $realtime, got.keys_locked, got.standby_request, got.standby_cause,
                     got.idle_ms);
         error_count++;
      end else begin
         want = pending_results.pop_front();
         if (got.keys_locked !== want.keys_locked ||
             got.standby_request !== want.standby_request ||
             got.standby_cause !== want.standby_cause ||
             got.idle_ms !== want.idle_ms) begin
            if (error_count < 10)
               $display("%0t: result %0d: expected lock=%0b req=%0b cause=%0d idle=%0d, %s",
                        $realtime, results_checked, want.keys_locked, want.standby_request,
                        want.standby_cause, want.idle_ms,
                        $sformatf("got lock=%0b req=%0b cause=%0d idle=%0d", got.keys_locked,
                                  got.standby_request, got.standby_cause, got.idle_ms));
            error_count++;
         end
      end
      results_checked++;
      if (got.standby_request === 1'b1) standby_by_cause[got.standby_cause]++;
   endtask

   // Result side: random stalls, then take and check one transaction
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
         gap = recv_calm ? 0 : $urandom_range(0, 6);
         repeat (gap) begin
            @(negedge clock);
            rsp_chan.ready = 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         check_result();
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Main sequence
   initial begin
      reset                       = 1'b1;
      csr_we                      = 1'b0;
      csr_index                   = CSR_STANDBY_MINUTES;
      csr_wdata                   = '0;
      req_chan.valid              = 1'b0;
      req_chan.now_ms             = '0;
      req_chan.button_down        = 1'b0;
      req_chan.external_power     = 1'b0;
      req_chan.battery_mv         = '0;
      req_chan.battery_pct        = '0;
      req_chan.playback_active    = 1'b0;
      req_chan.file_server_active = 1'b0;
      req_chan.user_activity      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table at reset settings
      // short press toggles lock, too-short press does not
      dir_rows.push_back(row(make_tick(0, 0, 0, 3800, 80, 0, 0, 0), 1, 0, 0, CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(10, 1, 0, 3800, 80, 0, 0, 0), 1, 0, 0, CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(60, 0, 0, 3800, 80, 0, 0, 0), 1, 1, 0, CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(100, 1, 0, 3800, 80, 0, 0, 0), 1, 1, 0, CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(139, 0, 0, 3800, 80, 0, 0, 0), 1, 1, 0, CAUSE_NONE, 39));
      // long press fires exactly at the limit, once
      dir_rows.push_back(row(make_tick(200, 1, 0, 3800, 80, 0, 0, 0), 1, 1, 0, CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(2199, 1, 0, 3800, 80, 0, 0, 0), 1, 1, 0, CAUSE_NONE, 1999));
      dir_rows.push_back(row(make_tick(2200, 1, 0, 3800, 80, 0, 0, 0), 1, 1, 1, CAUSE_LONG, 2000));
      dir_rows.push_back(row(make_tick(2400, 0, 0, 3800, 80, 0, 0, 0), 1, 1, 0, CAUSE_NONE, 2200));
      // critical battery hits, saturation, bus error, mains, threshold edge
      dir_rows.push_back(row(make_tick(30000, 0, 0, 3500, 5, 0, 0, 0), 1, 1, 0, CAUSE_NONE,
                             29800));
      dir_rows.push_back(row(make_tick(60000, 0, 0, 3500, 5, 0, 0, 0), 1, 1, 1, CAUSE_BATTERY,
                             59800));
      dir_rows.push_back(row(make_tick(60001, 0, 0, 3500, 5, 0, 0, 0), 1, 1, 0, CAUSE_NONE,
                             59801));
      dir_rows.push_back(row(make_tick(90001, 0, 0, 101, 0, 0, 0, 0), 1, 1, 1, CAUSE_BATTERY,
                             89801));
      dir_rows.push_back(row(make_tick(120001, 0, 0, 100, 0, 0, 0, 0), 1, 1, 0, CAUSE_NONE,
                             119801));
      dir_rows.push_back(row(make_tick(150001, 0, 1, 3500, 5, 0, 0, 0), 1, 1, 0, CAUSE_NONE,
                             149801));
      dir_rows.push_back(row(make_tick(180001, 0, 0, 16'hFFFF, 6, 0, 0, 0), 1, 1, 0,
                             CAUSE_NONE, 179801));
      // idle timeout, held off by playback and by file server on mains only
      dir_rows.push_back(row(make_tick(300200, 0, 0, 3800, 80, 0, 0, 0), 1, 1, 1, CAUSE_IDLE,
                             300000));
      dir_rows.push_back(row(make_tick(300201, 0, 0, 3800, 80, 1, 0, 0), 1, 1, 0, CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(600201, 0, 1, 3800, 80, 0, 1, 0), 1, 1, 0, CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(900201, 0, 0, 3800, 80, 0, 1, 0), 1, 1, 1, CAUSE_IDLE,
                             300000));
      dir_rows.push_back(row(make_tick(900300, 0, 0, 3800, 80, 0, 0, 1), 1, 1, 0, CAUSE_NONE, 0));
      // press across the time wrap, then a press starting at time zero
      dir_rows.push_back(row(make_tick(32'hFFFF_FFF0, 0, 0, 3800, 80, 0, 0, 1), 0, 0, 0,
                             CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(32'hFFFF_FFF8, 1, 0, 3800, 100, 0, 0, 0), 0, 0, 0,
                             CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(32'h28, 0, 0, 3800, 99, 0, 0, 0), 0, 0, 0,
                             CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(0, 1, 0, 3800, 64, 0, 0, 0), 0, 0, 0, CAUSE_NONE, 0));
      dir_rows.push_back(row(make_tick(50, 0, 0, 3800, 63, 0, 0, 0), 0, 0, 0, CAUSE_NONE, 0));
      foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].outcome);
      sim_now = 50;

      // Random sequences under reset settings, then fixed and random settings
      random_phase(300);
      load_settings(1, 100, 10, 50, 500, 1, 0);
      random_phase(300);
      load_settings(255, 16'hFFFF, 16'hFFFF, 127, 20'hFFFFF, 3, 16'hFFFF);
      random_phase(250);
      load_settings(0, 0, 0, 0, 0, 0, 0);
      random_phase(250);
      repeat (4) begin
         load_settings(20'($urandom_range(0, 10)), 20'($urandom_range(0, 5000)),
                       20'($urandom_range(0, 300)), 20'($urandom_range(0, 100)),
                       20'($urandom_range(0, 60000)), 20'($urandom_range(0, 3)),
                       20'($urandom_range(0, 4000)));
         random_phase(175);
      end

      // Drain and let any stray result show up
      await_quiet();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0d expected results never arrived", pending_results.size());
         error_count += pending_results.size();
      end

      $display("%0d poll ticks, %0d results checked over %0d register settings, %0d lock toggles",
               ticks_sent, results_checked, settings_loaded, lock_toggles);
      $display("standby requests: battery %0d, long press %0d, idle %0d; %0d errors",
               standby_by_cause[CAUSE_BATTERY], standby_by_cause[CAUSE_LONG],
               standby_by_cause[CAUSE_IDLE], error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
